### rtl/gfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_pkg
// Shared sizes and request codes for the greedy feedback-arc order unit.
// ----------------------------------------------------------------------------
package gfa_pkg;

    localparam int MAX_V  = 64;
    localparam int MAX_E  = 512;
    localparam int ID_W   = 24;
    localparam int VI_W   = $clog2(MAX_V);
    localparam int VC_W   = $clog2(MAX_V + 1);
    localparam int EI_W   = $clog2(MAX_E);
    localparam int EC_W   = $clog2(MAX_E + 1);
    localparam int DEG_W  = EC_W;
    localparam int EDGE_W = 2 * VI_W;

    typedef enum logic [1:0] {
        MODE_VERTEX = 2'd0,
        MODE_EDGE   = 2'd1,
        MODE_RUN    = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RET_SINK,
        RET_SRC,
        RET_MAX
    } ret_t;

endpackage

### rtl/gfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gfa_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/greedy_feedback_arc_order_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_feedback_arc_order_unit
// Loads one strongly connected component and emits a greedy feedback-arc
// vertex order (sinks to the right, sources to the left, else max out-in).
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  request  | item_valid/ready, mode, ids      | in
//  result   | result_valid/ready, order_id ... | out
//
//  Vertex load: written directly. Edge load: a scan of the vertex table.
//  Run: an initial degree scan, then per removal a pass over the stored edges,
//  a max search scan, two reads per emitted vertex; one read per memory a cycle.
//  One request at a time; a stalled result holds the unit in its emit step.
//  Reset is asynchronous; stores are cleared at the end of every run.
// ----------------------------------------------------------------------------
module greedy_feedback_arc_order_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic [1:0]                mode,
    input  logic [gfa_pkg::ID_W-1:0]  vertex_id,
    input  logic [gfa_pkg::ID_W-1:0]  row_id,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [gfa_pkg::ID_W-1:0]  order_id,
    output logic                      last,
    output logic                      overflow
);
    import gfa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_ESCAN, S_EINC, S_ISCAN, S_LOOP, S_DSINK, S_DSINKW, S_DSRC,
        S_DSRCW, S_MSCAN, S_REDGE, S_RCHK, S_RDEG, S_EMIT, S_XRD, S_XVT,
        S_XLD, S_XWAIT, S_CLEAR
    } state_t;

    state_t state_reg, state_next;
    logic [VC_W-1:0]  vcount_reg, vcount_next;
    logic [EC_W-1:0]  ecount_reg, ecount_next;
    logic [EC_W-1:0]  idx_reg, idx_next;
    logic             pv_reg, pv_next;
    logic [VI_W-1:0]  pidx_reg, pidx_next;
    logic [ID_W-1:0]  col_reg, col_next, row_reg, row_next;
    logic             c_ok_reg, c_ok_next, r_ok_reg, r_ok_next;
    logic [VI_W-1:0]  c_idx_reg, c_idx_next, r_idx_reg, r_idx_next;
    logic [MAX_V-1:0] in_vld_reg, in_vld_next, out_vld_reg, out_vld_next;
    logic             in_vq_reg, out_vq_reg;
    logic [MAX_V-1:0] alive_reg, alive_next;
    logic [VC_W-1:0]  remain_reg, remain_next;
    logic [VC_W-1:0]  sk_head_reg, sk_head_next, sk_tail_reg, sk_tail_next;
    logic [VC_W-1:0]  sr_head_reg, sr_head_next, sr_tail_reg, sr_tail_next;
    logic [VC_W-1:0]  lcnt_reg, lcnt_next, rcnt_reg, rcnt_next;
    logic             ovf_reg, ovf_next;
    logic [VI_W-1:0]  u_reg, u_next, dv_reg, dv_next;
    ret_t             ret_reg, ret_next;
    logic             dk_reg, dk_next;
    logic             best_ok_reg, best_ok_next;
    logic [VI_W-1:0]  best_reg, best_next;
    logic signed [DEG_W:0] bestd_reg, bestd_next;
    logic [VC_W-1:0]  n_reg, n_next;
    logic             rv_reg, rv_next, last_reg, last_next, ovo_reg, ovo_next;
    logic [ID_W-1:0]  oid_reg, oid_next;

    logic              vt_we;
    logic [VI_W-1:0]   vt_waddr, vt_raddr;
    logic [ID_W-1:0]   vt_rdata;
    logic              ed_we;
    logic [EI_W-1:0]   ed_waddr, ed_raddr;
    logic [EDGE_W-1:0] ed_wdata, ed_rdata;
    logic              id_we, od_we;
    logic [VI_W-1:0]   id_waddr, od_waddr, id_raddr, od_raddr;
    logic [DEG_W-1:0]  id_wdata, od_wdata, id_rdata, od_rdata;
    logic              sk_we, sr_we, or_we;
    logic [VI_W-1:0]   sk_waddr, sr_waddr, or_waddr, sk_raddr, sr_raddr, or_raddr;
    logic [VI_W-1:0]   sk_wdata, sr_wdata, or_wdata, sk_rdata, sr_rdata, or_rdata;

    logic [DEG_W-1:0]  in_d, out_d, dec_in, dec_out;
    logic [VI_W-1:0]   e_src, e_dst;
    logic [VC_W:0]     total;
    logic [VC_W-1:0]   n_off;
    logic signed [DEG_W:0] diff;

    gfa_ram #(.W(ID_W), .D(MAX_V)) u_vtab (
        .clk(clk), .we(vt_we), .waddr(vt_waddr), .wdata(vertex_id),
        .raddr(vt_raddr), .rdata(vt_rdata));
    gfa_ram #(.W(EDGE_W), .D(MAX_E)) u_edge (
        .clk(clk), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
        .raddr(ed_raddr), .rdata(ed_rdata));
    gfa_ram #(.W(DEG_W), .D(MAX_V)) u_indeg (
        .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
        .raddr(id_raddr), .rdata(id_rdata));
    gfa_ram #(.W(DEG_W), .D(MAX_V)) u_outdeg (
        .clk(clk), .we(od_we), .waddr(od_waddr), .wdata(od_wdata),
        .raddr(od_raddr), .rdata(od_rdata));
    gfa_ram #(.W(VI_W), .D(MAX_V)) u_sinkq (
        .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
        .raddr(sk_raddr), .rdata(sk_rdata));
    gfa_ram #(.W(VI_W), .D(MAX_V)) u_srcq (
        .clk(clk), .we(sr_we), .waddr(sr_waddr), .wdata(sr_wdata),
        .raddr(sr_raddr), .rdata(sr_rdata));
    gfa_ram #(.W(VI_W), .D(MAX_V)) u_order (
        .clk(clk), .we(or_we), .waddr(or_waddr), .wdata(or_wdata),
        .raddr(or_raddr), .rdata(or_rdata));

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = rv_reg;
    assign order_id     = oid_reg;
    assign last         = last_reg;
    assign overflow     = ovo_reg;

    assign in_d    = in_vq_reg ? id_rdata : '0;
    assign out_d   = out_vq_reg ? od_rdata : '0;
    assign dec_in  = (in_d != '0) ? in_d - 1'b1 : '0;
    assign dec_out = (out_d != '0) ? out_d - 1'b1 : '0;
    assign e_src   = ed_rdata[EDGE_W-1:VI_W];
    assign e_dst   = ed_rdata[VI_W-1:0];
    assign total   = {1'b0, lcnt_reg} + {1'b0, rcnt_reg};
    assign n_off   = VC_W'({1'b0, n_reg} - total);
    assign diff    = $signed({1'b0, out_d}) - $signed({1'b0, in_d});

    always_comb
    begin
        state_next   = state_reg;
        vcount_next  = vcount_reg;
        ecount_next  = ecount_reg;
        idx_next     = idx_reg;
        pv_next      = 1'b0;
        pidx_next    = pidx_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        c_ok_next    = c_ok_reg;
        r_ok_next    = r_ok_reg;
        c_idx_next   = c_idx_reg;
        r_idx_next   = r_idx_reg;
        in_vld_next  = in_vld_reg;
        out_vld_next = out_vld_reg;
        alive_next   = alive_reg;
        remain_next  = remain_reg;
        sk_head_next = sk_head_reg;
        sk_tail_next = sk_tail_reg;
        sr_head_next = sr_head_reg;
        sr_tail_next = sr_tail_reg;
        lcnt_next    = lcnt_reg;
        rcnt_next    = rcnt_reg;
        ovf_next     = ovf_reg;
        u_next       = u_reg;
        dv_next      = dv_reg;
        ret_next     = ret_reg;
        dk_next      = dk_reg;
        best_ok_next = best_ok_reg;
        best_next    = best_reg;
        bestd_next   = bestd_reg;
        n_next       = n_reg;
        rv_next      = rv_reg;
        last_next    = last_reg;
        ovo_next     = ovo_reg;
        oid_next     = oid_reg;

        vt_we    = 1'b0;
        vt_waddr = vcount_reg[VI_W-1:0];
        vt_raddr = idx_reg[VI_W-1:0];
        ed_we    = 1'b0;
        ed_waddr = ecount_reg[EI_W-1:0];
        ed_wdata = {c_idx_reg, r_idx_reg};
        ed_raddr = idx_reg[EI_W-1:0];
        id_we    = 1'b0;
        id_waddr = r_idx_reg;
        id_wdata = in_d + 1'b1;
        id_raddr = idx_reg[VI_W-1:0];
        od_we    = 1'b0;
        od_waddr = c_idx_reg;
        od_wdata = out_d + 1'b1;
        od_raddr = idx_reg[VI_W-1:0];
        sk_we    = 1'b0;
        sk_waddr = sk_tail_reg[VI_W-1:0];
        sk_wdata = pidx_reg;
        sk_raddr = sk_head_reg[VI_W-1:0];
        sr_we    = 1'b0;
        sr_waddr = sr_tail_reg[VI_W-1:0];
        sr_wdata = pidx_reg;
        sr_raddr = sr_head_reg[VI_W-1:0];
        or_we    = 1'b0;
        or_waddr = lcnt_reg[VI_W-1:0];
        or_wdata = u_reg;
        or_raddr = (n_reg < lcnt_reg) ? n_reg[VI_W-1:0] : n_off[VI_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                col_next = vertex_id;
                row_next = row_id;
                if (item_valid)
                begin
                    idx_next = '0;
                    unique case (mode)
                        MODE_VERTEX:
                        begin
                            if (vcount_reg < VC_W'(MAX_V))
                            begin
                                vt_we       = 1'b1;
                                vcount_next = vcount_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_EDGE:
                        begin
                            c_ok_next = 1'b0;
                            r_ok_next = 1'b0;
                            if (vertex_id != row_id)
                            begin
                                state_next = S_ESCAN;
                            end
                        end
                        MODE_RUN:
                        begin
                            remain_next = vcount_reg;
                            state_next  = S_ISCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ESCAN:
            begin
                id_raddr = r_idx_reg;
                od_raddr = c_idx_reg;
                if (idx_reg < EC_W'(vcount_reg))
                begin
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[VI_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    if (vt_rdata == col_reg)
                    begin
                        c_ok_next  = 1'b1;
                        c_idx_next = pidx_reg;
                    end
                    if (vt_rdata == row_reg)
                    begin
                        r_ok_next  = 1'b1;
                        r_idx_next = pidx_reg;
                    end
                end
                else if (idx_reg >= EC_W'(vcount_reg))
                begin
                    state_next = S_IDLE;
                    if (c_ok_reg && r_ok_reg)
                    begin
                        if (ecount_reg >= EC_W'(MAX_E))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ed_we      = 1'b1;
                            state_next = S_EINC;
                        end
                    end
                end
            end
            S_EINC:
            begin
                id_we       = 1'b1;
                od_we       = 1'b1;
                in_vld_next[r_idx_reg]  = 1'b1;
                out_vld_next[c_idx_reg] = 1'b1;
                ecount_next = ecount_reg + 1'b1;
                state_next  = S_IDLE;
            end
            S_ISCAN:
            begin
                if (idx_reg < EC_W'(vcount_reg))
                begin
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[VI_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    if (out_d == '0)
                    begin
                        if (sk_tail_reg < VC_W'(MAX_V))
                        begin
                            sk_we        = 1'b1;
                            sk_tail_next = sk_tail_reg + 1'b1;
                        end
                    end
                    else if (in_d == '0)
                    begin
                        if (sr_tail_reg < VC_W'(MAX_V))
                        begin
                            sr_we        = 1'b1;
                            sr_tail_next = sr_tail_reg + 1'b1;
                        end
                    end
                end
                else if (idx_reg >= EC_W'(vcount_reg))
                begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                state_next = (remain_reg != '0) ? S_DSINK : S_EMIT;
            end
            S_DSINK:
            begin
                if (sk_head_reg < sk_tail_reg)
                begin
                    sk_head_next = sk_head_reg + 1'b1;
                    state_next   = S_DSINKW;
                end
                else
                begin
                    state_next = S_DSRC;
                end
            end
            S_DSINKW:
            begin
                state_next = S_DSINK;
                if (alive_reg[sk_rdata])
                begin
                    u_next     = sk_rdata;
                    ret_next   = RET_SINK;
                    alive_next[sk_rdata] = 1'b0;
                    remain_next = remain_reg - 1'b1;
                    idx_next   = '0;
                    state_next = S_REDGE;
                end
            end
            S_DSRC:
            begin
                if (sr_head_reg < sr_tail_reg)
                begin
                    sr_head_next = sr_head_reg + 1'b1;
                    state_next   = S_DSRCW;
                end
                else if (remain_reg != '0)
                begin
                    idx_next     = '0;
                    best_ok_next = 1'b0;
                    state_next   = S_MSCAN;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            S_DSRCW:
            begin
                state_next = S_DSRC;
                if (alive_reg[sr_rdata])
                begin
                    u_next     = sr_rdata;
                    ret_next   = RET_SRC;
                    alive_next[sr_rdata] = 1'b0;
                    remain_next = remain_reg - 1'b1;
                    idx_next   = '0;
                    state_next = S_REDGE;
                end
            end
            S_MSCAN:
            begin
                if (idx_reg < EC_W'(vcount_reg))
                begin
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[VI_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    if (alive_reg[pidx_reg] && (!best_ok_reg || diff > bestd_reg))
                    begin
                        best_ok_next = 1'b1;
                        best_next    = pidx_reg;
                        bestd_next   = diff;
                    end
                end
                else if (idx_reg >= EC_W'(vcount_reg))
                begin
                    if (best_ok_reg)
                    begin
                        u_next     = best_reg;
                        ret_next   = RET_MAX;
                        alive_next[best_reg] = 1'b0;
                        remain_next = remain_reg - 1'b1;
                        idx_next   = '0;
                        state_next = S_REDGE;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_REDGE:
            begin
                if (idx_reg < ecount_reg)
                begin
                    state_next = S_RCHK;
                end
                else
                begin
                    unique case (ret_reg)
                        RET_SINK:
                        begin
                            or_waddr = VI_W'(MAX_V - 1) - rcnt_reg[VI_W-1:0];
                            if (rcnt_reg < VC_W'(MAX_V))
                            begin
                                or_we     = 1'b1;
                                rcnt_next = rcnt_reg + 1'b1;
                            end
                            state_next = S_DSINK;
                        end
                        RET_SRC, RET_MAX:
                        begin
                            if (lcnt_reg < VC_W'(MAX_V))
                            begin
                                or_we     = 1'b1;
                                lcnt_next = lcnt_reg + 1'b1;
                            end
                            state_next = (ret_reg == RET_SRC) ? S_DSRC : S_LOOP;
                        end
                        default:
                        begin
                            state_next = S_LOOP;
                        end
                    endcase
                end
            end
            S_RCHK:
            begin
                id_raddr = e_dst;
                od_raddr = e_src;
                if (e_src == u_reg && alive_reg[e_dst])
                begin
                    dv_next    = e_dst;
                    dk_next    = 1'b1;
                    state_next = S_RDEG;
                end
                else if (e_dst == u_reg && alive_reg[e_src])
                begin
                    dv_next    = e_src;
                    dk_next    = 1'b0;
                    state_next = S_RDEG;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_REDGE;
                end
            end
            S_RDEG:
            begin
                id_waddr = dv_reg;
                od_waddr = dv_reg;
                id_wdata = dec_in;
                od_wdata = dec_out;
                sk_wdata = dv_reg;
                sr_wdata = dv_reg;
                if (dk_reg)
                begin
                    id_we = 1'b1;
                    in_vld_next[dv_reg] = 1'b1;
                    if (dec_in == '0 && sr_tail_reg < VC_W'(MAX_V))
                    begin
                        sr_we        = 1'b1;
                        sr_tail_next = sr_tail_reg + 1'b1;
                    end
                end
                else
                begin
                    od_we = 1'b1;
                    out_vld_next[dv_reg] = 1'b1;
                    if (dec_out == '0 && sk_tail_reg < VC_W'(MAX_V))
                    begin
                        sk_we        = 1'b1;
                        sk_tail_next = sk_tail_reg + 1'b1;
                    end
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_REDGE;
            end
            S_EMIT:
            begin
                n_next     = '0;
                state_next = (total == '0) ? S_CLEAR : S_XRD;
            end
            S_XRD:
            begin
                state_next = S_XVT;
            end
            S_XVT:
            begin
                vt_raddr   = or_rdata;
                state_next = S_XLD;
            end
            S_XLD:
            begin
                oid_next   = vt_rdata;
                last_next  = ({1'b0, n_reg} + 1'b1 == total);
                ovo_next   = ovf_reg;
                rv_next    = 1'b1;
                state_next = S_XWAIT;
            end
            S_XWAIT:
            begin
                if (result_ready)
                begin
                    rv_next    = 1'b0;
                    n_next     = n_reg + 1'b1;
                    state_next = ({1'b0, n_reg} + 1'b1 == total) ? S_CLEAR : S_XRD;
                end
            end
            S_CLEAR:
            begin
                vcount_next  = '0;
                ecount_next  = '0;
                in_vld_next  = '0;
                out_vld_next = '0;
                alive_next   = '1;
                remain_next  = '0;
                sk_head_next = '0;
                sk_tail_next = '0;
                sr_head_next = '0;
                sr_tail_next = '0;
                lcnt_next    = '0;
                rcnt_next    = '0;
                ovf_next     = 1'b0;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vcount_reg  <= '0;
            ecount_reg  <= '0;
            pv_reg      <= 1'b0;
            in_vld_reg  <= '0;
            out_vld_reg <= '0;
            in_vq_reg   <= 1'b0;
            out_vq_reg  <= 1'b0;
            alive_reg   <= '1;
            remain_reg  <= '0;
            sk_head_reg <= '0;
            sk_tail_reg <= '0;
            sr_head_reg <= '0;
            sr_tail_reg <= '0;
            lcnt_reg    <= '0;
            rcnt_reg    <= '0;
            ovf_reg     <= 1'b0;
            best_ok_reg <= 1'b0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vcount_reg  <= vcount_next;
            ecount_reg  <= ecount_next;
            pv_reg      <= pv_next;
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            in_vq_reg   <= in_vld_reg[id_raddr];
            out_vq_reg  <= out_vld_reg[od_raddr];
            alive_reg   <= alive_next;
            remain_reg  <= remain_next;
            sk_head_reg <= sk_head_next;
            sk_tail_reg <= sk_tail_next;
            sr_head_reg <= sr_head_next;
            sr_tail_reg <= sr_tail_next;
            lcnt_reg    <= lcnt_next;
            rcnt_reg    <= rcnt_next;
            ovf_reg     <= ovf_next;
            best_ok_reg <= best_ok_next;
            rv_reg      <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pidx_reg  <= pidx_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        c_ok_reg  <= c_ok_next;
        r_ok_reg  <= r_ok_next;
        c_idx_reg <= c_idx_next;
        r_idx_reg <= r_idx_next;
        u_reg     <= u_next;
        dv_reg    <= dv_next;
        ret_reg   <= ret_next;
        dk_reg    <= dk_next;
        best_reg  <= best_next;
        bestd_reg <= bestd_next;
        n_reg     <= n_next;
        last_reg  <= last_next;
        ovo_reg   <= ovo_next;
        oid_reg   <= oid_next;
    end

    a_valid_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> (state_reg == S_XWAIT))
        else $error("result shown outside emit wait");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (sk_tail_reg == '0 && sr_tail_reg == '0 &&
                                   lcnt_reg == '0 && rcnt_reg == '0))
        else $error("run stores not cleared");

    a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total <= {1'b0, vcount_reg})
        else $error("more vertices ordered than loaded");

    a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VC_W'(MAX_V))
        else $error("vertex count beyond table");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for greedy_feedback_arc_order_unit. A directed table covers id
// extremes, empty and single-vertex runs, self-loops, unknown edge ends and
// ignored requests. It is followed by random graphs, including vertex table
// overflow. A local greedy-order predictor checks every result.
// ----------------------------------------------------------------------------
module tb_top;
    import gfa_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int TOTAL_REQS  = 450;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    logic [1:0]       mode;
    logic [ID_W-1:0]  vertex_id;
    logic [ID_W-1:0]  row_id;
    logic             result_valid;
    logic             result_ready;
    logic [ID_W-1:0]  order_id;
    logic             last;
    logic             overflow;

    greedy_feedback_arc_order_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .vertex_id    (vertex_id),
        .row_id       (row_id),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .order_id     (order_id),
        .last         (last),
        .overflow     (overflow)
    );

    // greedy order state
    logic [ID_W-1:0] vtab [MAX_V];
    int              vcount;
    int              esrc [MAX_E];
    int              edst [MAX_E];
    int              ecount;
    int              indeg [MAX_V];
    int              outdeg [MAX_V];
    bit   [63:0]     alive;
    int              sinkq [MAX_V];
    int              sink_hd, sink_tl;
    int              srcq [MAX_V];
    int              src_hd, src_tl;
    int              leftl [MAX_V];
    int              left_n;
    int              rstack [MAX_V];
    int              right_n;
    bit              ovf_flag;
    int              remaining;

    logic [ID_W-1:0] exp_id [$];
    bit              exp_last [$];
    bit              exp_ovf [$];

    int  errors;
    int  cycles;
    bit  quiet;

    typedef struct {
        mode_t           m;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        bit              typed;
        logic [ID_W-1:0] eid;
        bit              elast;
        bit              eovf;
    } row_t;

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'($urandom);
    endfunction

    function automatic void expect_result(logic [ID_W-1:0] id, bit lst, bit ov);
        exp_id   = {exp_id, id};
        exp_last = {exp_last, lst};
        exp_ovf  = {exp_ovf, ov};
    endfunction

    function automatic void order_clear();
        vcount = 0;
        ecount = 0;
        for (int i = 0; i < MAX_V; i++)
        begin
            indeg[i] = 0;
            outdeg[i] = 0;
        end
        alive = '1;
        sink_hd = 0; sink_tl = 0;
        src_hd = 0; src_tl = 0;
        left_n = 0; right_n = 0;
        ovf_flag = 0;
        remaining = 0;
    endfunction

    function automatic int lookup_local(logic [ID_W-1:0] id);
        int hit;
        hit = -1;
        for (int i = 0; i < vcount; i++)
            if (vtab[i] == id)
                hit = i;
        return hit;
    endfunction

    function automatic void push_sink(int v);
        if (sink_tl < MAX_V)
        begin
            sinkq[sink_tl] = v;
            sink_tl++;
        end
    endfunction

    function automatic void push_source(int v);
        if (src_tl < MAX_V)
        begin
            srcq[src_tl] = v;
            src_tl++;
        end
    endfunction

    function automatic void drop_vertex(int u);
        int v;
        alive[u] = 0;
        if (remaining > 0)
            remaining--;
        for (int e = 0; e < ecount; e++)
        begin
            v = edst[e];
            if (esrc[e] != u || !alive[v])
                continue;
            if (indeg[v] > 0)
                indeg[v]--;
            if (indeg[v] == 0)
                push_source(v);
        end
        for (int e = 0; e < ecount; e++)
        begin
            v = esrc[e];
            if (edst[e] != u || !alive[v])
                continue;
            if (outdeg[v] > 0)
                outdeg[v]--;
            if (outdeg[v] == 0)
                push_sink(v);
        end
    endfunction

    function automatic void greedy_order();
        int u, best, d, best_d;
        for (int i = 0; i < vcount; i++)
        begin
            if (outdeg[i] == 0)
                push_sink(i);
            else if (indeg[i] == 0)
                push_source(i);
        end
        remaining = vcount;
        while (remaining > 0)
        begin
            while (sink_hd < sink_tl)
            begin
                u = sinkq[sink_hd];
                sink_hd++;
                if (!alive[u])
                    continue;
                drop_vertex(u);
                if (right_n < MAX_V)
                begin
                    rstack[right_n] = u;
                    right_n++;
                end
            end
            while (src_hd < src_tl)
            begin
                u = srcq[src_hd];
                src_hd++;
                if (!alive[u])
                    continue;
                drop_vertex(u);
                if (left_n < MAX_V)
                begin
                    leftl[left_n] = u;
                    left_n++;
                end
            end
            if (remaining > 0)
            begin
                best = -1;
                best_d = 0;
                for (int i = 0; i < vcount; i++)
                begin
                    if (!alive[i])
                        continue;
                    d = outdeg[i] - indeg[i];
                    if (best < 0 || d > best_d)
                    begin
                        best_d = d;
                        best = i;
                    end
                end
                if (best < 0)
                    break;
                drop_vertex(best);
                if (left_n < MAX_V)
                begin
                    leftl[left_n] = best;
                    left_n++;
                end
            end
        end
    endfunction

    // applies one accepted request; queues results unless told not to
    function automatic void order_apply(mode_t m, logic [ID_W-1:0] a, logic [ID_W-1:0] b,
                                        bit keep);
        int c, r, n, total;
        bit ov;
        case (m)
            MODE_VERTEX:
            begin
                if (vcount < MAX_V)
                begin
                    vtab[vcount] = a;
                    vcount++;
                end
                else
                    ovf_flag = 1;
            end
            MODE_EDGE:
            begin
                if (a != b)
                begin
                    c = lookup_local(a);
                    r = lookup_local(b);
                    if (c >= 0 && r >= 0)
                    begin
                        if (ecount >= MAX_E)
                            ovf_flag = 1;
                        else
                        begin
                            esrc[ecount] = c;
                            edst[ecount] = r;
                            ecount++;
                            outdeg[c]++;
                            indeg[r]++;
                        end
                    end
                end
            end
            MODE_RUN:
            begin
                ov = ovf_flag;
                greedy_order();
                total = left_n + right_n;
                n = 0;
                if (keep)
                begin
                    for (int i = 0; i < left_n; i++)
                    begin
                        n++;
                        expect_result(vtab[leftl[i]], n == total, ov);
                    end
                    for (int i = right_n; i > 0; i--)
                    begin
                        n++;
                        expect_result(vtab[rstack[i - 1]], n == total, ov);
                    end
                end
                order_clear();
            end
            default: ;
        endcase
    endfunction

    task automatic send_req(mode_t m, logic [ID_W-1:0] a, logic [ID_W-1:0] b,
                            bit typed = 0, logic [ID_W-1:0] eid = '0,
                            bit elast = 0, bit eovf = 0);
        @(negedge clk);
        if (!quiet && $urandom_range(99) < 17)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        item_valid <= 1'b1;
        mode       <= m;
        vertex_id  <= a;
        row_id     <= b;
        do
            @(posedge clk);
        while (!item_ready);
        order_apply(m, a, b, !typed);
        if (typed)
            expect_result(eid, elast, eovf);
    endtask

    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] id;
        do
            id = rand_id();
        while (lookup_local(id) >= 0);
        return id;
    endfunction

    // one graph: n vertices, ne edges with some noise, then a run
    task automatic load_graph(int n, int ne, inout int count);
        logic [ID_W-1:0] ids [$];
        logic [ID_W-1:0] a, b;
        int pick;
        ids.delete();
        for (int i = 0; i < n; i++)
        begin
            a = fresh_id();
            ids = {ids, a};
            send_req(MODE_VERTEX, a, rand_id());
            count++;
        end
        for (int i = 0; i < ne; i++)
        begin
            pick = $urandom_range(99);
            a = ids[$urandom_range(n - 1)];
            b = ids[$urandom_range(n - 1)];
            if (pick < 6)
                b = a;
            else if (pick < 12)
                b = rand_id();
            else if (pick < 15)
                a = rand_id();
            if (pick >= 97)
                send_req(MODE_NONE, rand_id(), rand_id());
            else
            begin
                send_req(MODE_EDGE, a, b);
                count++;
            end
        end
        send_req(MODE_RUN, rand_id(), rand_id());
        count++;
    endtask

    row_t dir_rows [] = '{
        '{MODE_RUN,    24'h000000, 24'h000000, 0, 24'h0, 0, 0},
        '{MODE_VERTEX, 24'hFFFFFF, 24'h000000, 0, 24'h0, 0, 0},
        '{MODE_RUN,    24'h000000, 24'hFFFFFF, 1, 24'hFFFFFF, 1, 0},
        '{MODE_VERTEX, 24'h000000, 24'hFFFFFF, 0, 24'h0, 0, 0},
        '{MODE_NONE,   24'h000000, 24'h000000, 0, 24'h0, 0, 0},
        '{MODE_RUN,    24'hFFFFFF, 24'hFFFFFF, 1, 24'h000000, 1, 0},
        '{MODE_VERTEX, 24'h000001, 24'h000000, 0, 24'h0, 0, 0},
        '{MODE_VERTEX, 24'hFFFFFE, 24'h000000, 0, 24'h0, 0, 0},
        '{MODE_VERTEX, 24'h800000, 24'h000000, 0, 24'h0, 0, 0},
        '{MODE_VERTEX, 24'h7FFFFF, 24'h000000, 0, 24'h0, 0, 0},
        '{MODE_EDGE,   24'h000001, 24'h000001, 0, 24'h0, 0, 0},
        '{MODE_EDGE,   24'h000001, 24'h123456, 0, 24'h0, 0, 0},
        '{MODE_EDGE,   24'h654321, 24'h800000, 0, 24'h0, 0, 0},
        '{MODE_NONE,   24'h000001, 24'hFFFFFE, 0, 24'h0, 0, 0},
        '{MODE_EDGE,   24'h000001, 24'hFFFFFE, 0, 24'h0, 0, 0},
        '{MODE_EDGE,   24'hFFFFFE, 24'h800000, 0, 24'h0, 0, 0},
        '{MODE_EDGE,   24'h800000, 24'h000001, 0, 24'h0, 0, 0},
        '{MODE_EDGE,   24'h000001, 24'h800000, 0, 24'h0, 0, 0},
        '{MODE_EDGE,   24'h7FFFFF, 24'h000001, 0, 24'h0, 0, 0},
        '{MODE_RUN,    24'h000000, 24'h000000, 0, 24'h0, 0, 0},
        '{MODE_VERTEX, 24'hABCDEF, 24'h000000, 0, 24'h0, 0, 0},
        '{MODE_VERTEX, 24'h555555, 24'h000000, 0, 24'h0, 0, 0},
        '{MODE_EDGE,   24'hABCDEF, 24'h555555, 0, 24'h0, 0, 0},
        '{MODE_RUN,    24'h000000, 24'h000000, 0, 24'h0, 0, 0}
    };

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        if (rst_n)
            result_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (exp_id.size() == 0)
            begin
                $display("%0t: unexpected result id=%h last=%b ovf=%b",
                         $time, order_id, last, overflow);
                errors++;
            end
            else
            begin
                if (order_id !== exp_id[0] || last !== exp_last[0]
                    || overflow !== exp_ovf[0])
                begin
                    $display("%0t: expected id=%h last=%b ovf=%b, got id=%h last=%b ovf=%b",
                             $time, exp_id[0], exp_last[0], exp_ovf[0],
                             order_id, last, overflow);
                    errors++;
                end
                void'(exp_id.pop_front());
                void'(exp_last.pop_front());
                void'(exp_ovf.pop_front());
            end
        end
    end

    initial
    begin
        int count;
        clk = 0;
        rst_n = 0;
        item_valid = 0;
        mode = MODE_NONE;
        vertex_id = '0;
        row_id = '0;
        result_ready = 0;
        errors = 0;
        cycles = 0;
        quiet = 0;
        count = 0;
        order_clear();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        foreach (dir_rows[i])
            send_req(dir_rows[i].m, dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed,
                     dir_rows[i].eid, dir_rows[i].elast, dir_rows[i].eovf);

        load_graph(MAX_V + 2, 40, count);
        load_graph(MAX_V, 60, count);
        while (count < TOTAL_REQS)
        begin
            quiet = (count > 250 && count < 350);
            if ($urandom_range(9) == 0)
                load_graph($urandom_range(12, 30), $urandom_range(10, 60), count);
            else
                load_graph($urandom_range(1, 8), $urandom_range(0, 16), count);
        end
        quiet = 0;
        @(negedge clk);
        item_valid <= 1'b0;
        wait (exp_id.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/gfa_pkg.sv
rtl/gfa_ram.sv
rtl/greedy_feedback_arc_order_unit.sv
dv/tb_top.sv
